[src/tgaluma_pkg.sv]
// shared types and constants of the tga luma stream unit
`default_nettype none
package tgaluma_pkg;

	// configuration port
	localparam int unsigned ADDR_W = 3;
	localparam int unsigned DATA_W = 32;
	localparam logic REG_BORDER_BLANK = 1'b0;
	localparam logic REG_SWAP_RED_BLUE = 1'b1;

	// header layout
	localparam logic [4:0] HDR_POS_ID_LEN = 5'd0;
	localparam logic [4:0] HDR_POS_TYPE = 5'd2;
	localparam logic [4:0] HDR_POS_WIDTH_LO = 5'd12;
	localparam logic [4:0] HDR_POS_WIDTH_HI = 5'd13;
	localparam logic [4:0] HDR_POS_HEIGHT_LO = 5'd14;
	localparam logic [4:0] HDR_POS_HEIGHT_HI = 5'd15;
	localparam logic [4:0] HDR_POS_DEPTH = 5'd16;
	localparam logic [4:0] HDR_POS_LAST = 5'd17;

	localparam logic [7:0] TGA_TYPE_RGB = 8'd2;
	localparam logic [7:0] TGA_DEPTH_24 = 8'd24;

	// result status codes
	localparam logic [1:0] STATUS_PIXEL = 2'd0;
	localparam logic [1:0] STATUS_BAD_TYPE = 2'd1;
	localparam logic [1:0] STATUS_BAD_DEPTH = 2'd2;

	localparam int unsigned LUMA_W = 24;
	localparam int unsigned QUEUE_DEPTH = 4;

	typedef struct packed {
		logic border_blank_enable;
		logic swap_red_blue;
	} cfg_t;

	// one classified item from the parser; color is zero for errors and blanked pixels
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [15:0] pixel_x;
		logic [15:0] pixel_y;
		logic last_pixel;
		logic [1:0] status;
	} job_t;

endpackage
`default_nettype wire

[src/tgaluma_ifs.sv]
// stream channel interfaces for file bytes and luma results
`default_nettype none
interface tgaluma_in_if;
	logic valid;
	logic ready;
	logic [7:0] file_byte;
	logic first_byte;
	modport source(output valid, file_byte, first_byte, input ready);
	modport sink(input valid, file_byte, first_byte, output ready);
endinterface

interface tgaluma_out_if;
	logic valid;
	logic ready;
	logic [23:0] luma;
	logic [15:0] pixel_x;
	logic [15:0] pixel_y;
	logic last_pixel;
	logic [1:0] status;
	modport source(output valid, luma, pixel_x, pixel_y, last_pixel, status, input ready);
	modport sink(input valid, luma, pixel_x, pixel_y, last_pixel, status, output ready);
endinterface
`default_nettype wire

[src/tgaluma_front.sv]
// header parser and pixel gatherer: turns file bytes into luma jobs
`default_nettype none
module tgaluma_front (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire tgaluma_pkg::cfg_t cfg,
	input  wire logic byte_fire,
	input  wire logic [7:0] file_byte,
	input  wire logic first_byte,
	output tgaluma_pkg::job_t job,
	output logic job_push
);
	import tgaluma_pkg::*;

	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_ID = 2'd1;
	localparam logic [1:0] PH_PIXELS = 2'd2;
	localparam logic [1:0] PH_IGNORE = 2'd3;

	logic [1:0] phase_q, phase_d, phase_eff;
	logic [4:0] hcount_q, hcount_d, hcount_eff;
	logic [7:0] id_left_q, id_left_d, id_dec;
	logic [7:0] type_q, type_d;
	logic [7:0] depth_q, depth_d;
	logic [15:0] width_q, width_d;
	logic [15:0] height_q, height_d;
	logic [15:0] col_q, col_d;
	logic [15:0] row_q, row_d;
	logic [1:0] chan_q, chan_d, chan_eff;
	logic [15:0] held_q, held_d;
	logic check;
	logic is_edge, is_last;

	assign phase_eff = first_byte ? PH_HEADER : phase_q;
	assign hcount_eff = first_byte ? 5'd0 : hcount_q;
	assign chan_eff = first_byte ? 2'd0 : chan_q;
	assign id_dec = id_left_q - 8'd1;

	assign is_edge = (col_q == 16'd0) || (col_q == width_q - 16'd1) ||
		(row_q == 16'd0) || (row_q == height_q - 16'd1);
	assign is_last = (col_q == width_q - 16'd1) && (row_q == height_q - 16'd1);

	always_comb begin
		phase_d = phase_q;
		hcount_d = hcount_q;
		id_left_d = id_left_q;
		type_d = type_q;
		depth_d = depth_q;
		width_d = width_q;
		height_d = height_q;
		col_d = col_q;
		row_d = row_q;
		chan_d = chan_q;
		held_d = held_q;
		check = 1'b0;
		job_push = 1'b0;
		job = '0;
		if (byte_fire) begin
			phase_d = phase_eff;
			hcount_d = hcount_eff;
			chan_d = chan_eff;
			unique case (phase_eff)
				PH_HEADER: begin
					unique case (hcount_eff)
						HDR_POS_ID_LEN: id_left_d = file_byte;
						HDR_POS_TYPE: type_d = file_byte;
						HDR_POS_WIDTH_LO: width_d = {width_q[15:8], file_byte};
						HDR_POS_WIDTH_HI: width_d = {file_byte, width_q[7:0]};
						HDR_POS_HEIGHT_LO: height_d = {height_q[15:8], file_byte};
						HDR_POS_HEIGHT_HI: height_d = {file_byte, height_q[7:0]};
						HDR_POS_DEPTH: depth_d = file_byte;
						default: ;
					endcase
					if (hcount_eff >= HDR_POS_LAST) begin
						hcount_d = 5'd0;
						if (id_left_q != 8'd0) begin
							phase_d = PH_ID;
						end else begin
							check = 1'b1;
						end
					end else begin
						hcount_d = hcount_eff + 5'd1;
					end
				end
				PH_ID: begin
					id_left_d = id_dec;
					check = (id_dec == 8'd0);
				end
				PH_PIXELS: begin
					unique case (chan_eff)
						2'd0: begin
							held_d[7:0] = file_byte;
							chan_d = 2'd1;
						end
						2'd1: begin
							held_d[15:8] = file_byte;
							chan_d = 2'd2;
						end
						default: begin
							chan_d = 2'd0;
							job_push = 1'b1;
							job.status = STATUS_PIXEL;
							job.pixel_x = col_q;
							job.pixel_y = row_q;
							job.last_pixel = is_last;
							// blanked border pixels go through as black
							if (!(cfg.border_blank_enable && is_edge)) begin
								job.green = held_q[15:8];
								job.red = cfg.swap_red_blue ? file_byte : held_q[7:0];
								job.blue = cfg.swap_red_blue ? held_q[7:0] : file_byte;
							end
							if (is_last) begin
								phase_d = PH_IGNORE;
							end else if ({1'b0, col_q} + 17'd1 >= {1'b0, width_q}) begin
								col_d = 16'd0;
								row_d = row_q + 16'd1;
							end else begin
								col_d = col_q + 16'd1;
							end
						end
					endcase
				end
				default: ;
			endcase
			if (check) begin
				col_d = 16'd0;
				row_d = 16'd0;
				chan_d = 2'd0;
				held_d = 16'd0;
				if (type_q != TGA_TYPE_RGB) begin
					phase_d = PH_IGNORE;
					job_push = 1'b1;
					job.status = STATUS_BAD_TYPE;
				end else if (depth_q != TGA_DEPTH_24) begin
					phase_d = PH_IGNORE;
					job_push = 1'b1;
					job.status = STATUS_BAD_DEPTH;
				end else begin
					phase_d = (width_q == 16'd0 || height_q == 16'd0) ? PH_IGNORE : PH_PIXELS;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			hcount_q <= '0;
			id_left_q <= '0;
			type_q <= '0;
			depth_q <= '0;
			width_q <= '0;
			height_q <= '0;
			col_q <= '0;
			row_q <= '0;
			chan_q <= '0;
			held_q <= '0;
		end else begin
			phase_q <= phase_d;
			hcount_q <= hcount_d;
			id_left_q <= id_left_d;
			type_q <= type_d;
			depth_q <= depth_d;
			width_q <= width_d;
			height_q <= height_d;
			col_q <= col_d;
			row_q <= row_d;
			chan_q <= chan_d;
			held_q <= held_d;
		end
	end

endmodule
`default_nettype wire

[src/tgaluma_queue.sv]
// short job queue between parser and luma pipeline
`default_nettype none
module tgaluma_queue (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire tgaluma_pkg::job_t push_job,
	output logic full,
	input  wire logic pop,
	output tgaluma_pkg::job_t pop_job,
	output logic not_empty
);
	import tgaluma_pkg::*;

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push, do_pop;

	assign full = (count_q == CNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push = push && !full;
	assign do_pop = pop && not_empty;
	assign pop_job = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			unique case ({do_push, do_pop})
				2'b10: count_q <= count_q + CNT_W'(1);
				2'b01: count_q <= count_q - CNT_W'(1);
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

[src/tgaluma_back.sv]
// two-stage luma pipeline: weighted products, then sum and saturate
`default_nettype none
module tgaluma_back #(
	parameter int unsigned WEIGHT_BITS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic job_valid,
	input  wire tgaluma_pkg::job_t job,
	output logic job_pop,
	output logic res_valid,
	input  wire logic res_ready,
	output logic [23:0] res_luma,
	output logic [15:0] res_pixel_x,
	output logic [15:0] res_pixel_y,
	output logic res_last_pixel,
	output logic [1:0] res_status
);
	import tgaluma_pkg::*;

	localparam int unsigned PROD_W = WEIGHT_BITS + 8;
	localparam int unsigned SUM_W = WEIGHT_BITS + 10;
	localparam int unsigned EXT_W = (SUM_W > LUMA_W) ? SUM_W : LUMA_W + 1;

	// bt.709 weights scaled by 2^WEIGHT_BITS, rounded half up
	localparam logic [WEIGHT_BITS-1:0] W_RED =
		WEIGHT_BITS'(((64'd2126 << WEIGHT_BITS) + 64'd5000) / 64'd10000);
	localparam logic [WEIGHT_BITS-1:0] W_GREEN =
		WEIGHT_BITS'(((64'd7152 << WEIGHT_BITS) + 64'd5000) / 64'd10000);
	localparam logic [WEIGHT_BITS-1:0] W_BLUE =
		WEIGHT_BITS'(((64'd722 << WEIGHT_BITS) + 64'd5000) / 64'd10000);

	logic adv;
	logic valid_s1;
	logic [PROD_W-1:0] prod_r_s1, prod_g_s1, prod_b_s1;
	logic [15:0] x_s1, y_s1;
	logic last_s1;
	logic [1:0] status_s1;
	logic [SUM_W-1:0] sum;
	logic [EXT_W-1:0] sum_ext;
	logic [LUMA_W-1:0] luma_sat;

	// whole pipe holds while the output item waits
	assign adv = !res_valid || res_ready;
	assign job_pop = adv && job_valid;

	assign sum = SUM_W'(prod_r_s1) + SUM_W'(prod_g_s1) + SUM_W'(prod_b_s1);
	assign sum_ext = EXT_W'(sum);
	assign luma_sat = (sum_ext[EXT_W-1:LUMA_W] != '0) ? '1 : sum_ext[LUMA_W-1:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_r_s1 <= PROD_W'(W_RED) * PROD_W'(job.red);
			prod_g_s1 <= PROD_W'(W_GREEN) * PROD_W'(job.green);
			prod_b_s1 <= PROD_W'(W_BLUE) * PROD_W'(job.blue);
			x_s1 <= job.pixel_x;
			y_s1 <= job.pixel_y;
			last_s1 <= job.last_pixel;
			status_s1 <= job.status;
			res_luma <= luma_sat;
			res_pixel_x <= x_s1;
			res_pixel_y <= y_s1;
			res_last_pixel <= last_s1;
			res_status <= status_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			res_valid <= 1'b0;
		end else if (adv) begin
			valid_s1 <= job_valid;
			res_valid <= valid_s1;
		end
	end

endmodule
`default_nettype wire

[src/tga_rgb_to_luma_stream_unit.sv]
// top level: tga byte stream in, bt.709 luma results out, apb register port
//
// channel  dir  accepted when          carries
// in_ch    in   valid && ready         file_byte, first_byte
// out_ch   out  valid && ready         luma, pixel_x, pixel_y, last_pixel, status
// apb      in   psel&penable&pwrite    border_blank_enable (0x0), swap_red_blue (0x4)
//
// one byte is taken per cycle while the job queue is not full; a pixel result follows every third pixel byte
// a result passes through the job queue, then the product stage, then the sum stage, each registered
// a four-entry job queue lets the parser keep taking bytes while out_ch stalls
// in_ch stalls only when that queue is full
// reset clears parse state and registers; nothing needs a clearing pass
`default_nettype none
module tga_rgb_to_luma_stream_unit #(
	parameter int unsigned WEIGHT_BITS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [tgaluma_pkg::ADDR_W-1:0] paddr,
	input  wire logic [tgaluma_pkg::DATA_W-1:0] pwdata,
	output logic [tgaluma_pkg::DATA_W-1:0] prdata,
	output logic pready,
	tgaluma_in_if.sink in_ch,
	tgaluma_out_if.source out_ch
);
	import tgaluma_pkg::*;

	cfg_t cfg_q;
	logic reg_sel;
	logic byte_fire;
	logic queue_full, queue_not_empty, queue_pop;
	logic job_push;
	job_t front_job, queue_job;

	assign pready = 1'b1;
	assign reg_sel = paddr[ADDR_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (reg_sel)
				REG_BORDER_BLANK: cfg_q.border_blank_enable <= pwdata[0];
				REG_SWAP_RED_BLUE: cfg_q.swap_red_blue <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_BORDER_BLANK: prdata = DATA_W'(cfg_q.border_blank_enable);
			REG_SWAP_RED_BLUE: prdata = DATA_W'(cfg_q.swap_red_blue);
			default: prdata = '0;
		endcase
	end

	assign in_ch.ready = !queue_full;
	assign byte_fire = in_ch.valid && !queue_full;

	tgaluma_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.byte_fire(byte_fire),
		.file_byte(in_ch.file_byte),
		.first_byte(in_ch.first_byte),
		.job(front_job),
		.job_push(job_push)
	);

	tgaluma_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(job_push),
		.push_job(front_job),
		.full(queue_full),
		.pop(queue_pop),
		.pop_job(queue_job),
		.not_empty(queue_not_empty)
	);

	tgaluma_back #(
		.WEIGHT_BITS(WEIGHT_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.job_valid(queue_not_empty),
		.job(queue_job),
		.job_pop(queue_pop),
		.res_valid(out_ch.valid),
		.res_ready(out_ch.ready),
		.res_luma(out_ch.luma),
		.res_pixel_x(out_ch.pixel_x),
		.res_pixel_y(out_ch.pixel_y),
		.res_last_pixel(out_ch.last_pixel),
		.res_status(out_ch.status)
	);

endmodule
`default_nettype wire
